>>> hw/rtl/hpg_pkg.sv
// Shared types, widths and constants for the helix point generator.
`timescale 1ns / 1ps

package hpg_pkg;

  // Field and register widths
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int IDX_IN_W   = 16;
  localparam int COORD_W    = 17;
  localparam int Y_W        = 16;
  localparam int TDATA_W    = 56;

  // Parameter defaults
  localparam int INDEX_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_RADIUS = 16'd256;
  localparam logic [CFG_W-1:0] RST_LENGTH = 16'd256;
  localparam logic [CFG_W-1:0] RST_COUNT  = 16'd100;
  localparam logic [CFG_W-1:0] RST_TURNS  = 16'd256;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_LENGTH = 2'd1,
    REG_COUNT  = 2'd2,
    REG_TURNS  = 2'd3
  } cfg_reg_t;

  // Q1.30 constants for the sine/cosine unit
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [29:0] Q30_QUARTER = 30'h2000_0000;
  localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;
  localparam logic [47:0] Q30_RND     = 48'h0000_2000_0000;

  // Taylor series: four Horner steps per function, then a final multiply.
  // Division by a small constant k uses m = ceil(2^(30+l)/k), l = ceil(log2 k),
  // which is exact for every dividend below 2^30.
  localparam int HORNER_STEPS = 4;
  localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SH [HORNER_STEPS] = '{37, 36, 35, 33};
  localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12)
  };
  localparam int COS_SH [HORNER_STEPS] = '{37, 36, 35, 34};

  // Sine/cosine unit stages: fold, square, Horner steps, final terms,
  // quadrant map, radius scale, sign
  localparam int SC_LAT = 2 + 3 * HORNER_STEPS + 2 + 2;

  // Per-point flags that travel beside the arithmetic
  typedef struct packed {
    logic is_last;
    logic in_range;
  } pt_flags_t;

  // One finished result
  typedef struct packed {
    logic signed [COORD_W-1:0] z_coord;
    logic [Y_W-1:0]            y_coord;
    logic signed [COORD_W-1:0] x_coord;
    logic                      is_last;
    logic                      in_range;
  } pt_result_t;

endpackage

>>> hw/rtl/hpg_delay.sv
// Shift line with enable, used to carry payload and valid bits beside the datapath.
`timescale 1ns / 1ps

module hpg_delay #(
  parameter int WIDTH = 1,
  parameter int LEN   = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_r [LEN];

  // Shift one place per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEN; i++) begin
        sr_r[i] <= '0;
      end
    end else if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < LEN; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[LEN-1];

endmodule

>>> hw/rtl/hpg_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, low quotient bits kept.
`timescale 1ns / 1ps

module hpg_div_pipe #(
  parameter int NUM_W = 41,
  parameter int DIV_W = 16,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] div_i,  // nonzero, held steady while items are in flight
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [QUO_W-1:0] quo_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // Bring down the next numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, div_i};
    assign ge    = (trial >= {1'b0, div_i});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= {quo_in[QUO_W-2:0], ge};
      end
    end

    if (i < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
          num_r[i] <= num_in << 1;
        end
      end
    end
  end

  assign quo_o = quo_r[NUM_W-1];

endmodule

>>> hw/rtl/hpg_sincos.sv
// Pipelined radius*cos / radius*sin from a phase in turns, Taylor series on one octant.
`timescale 1ns / 1ps

module hpg_sincos #(
  parameter int ANGLE_BITS = hpg_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [hpg_pkg::CFG_W-1:0]           radius_i,
  input  logic [ANGLE_BITS-1:0]               ang_i,
  output logic signed [hpg_pkg::COORD_W-1:0]  x_o,
  output logic signed [hpg_pkg::COORD_W-1:0]  z_o
);

  import hpg_pkg::*;

  typedef struct packed {
    logic [29:0] th;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Fold the angle into the first octant
  logic [31:0] u_c;
  logic [29:0] r_c;
  logic [29:0] rs_c;
  logic        swap_c;
  logic [60:0] th_prod;
  logic [29:0] th1_r;
  logic [1:0]  quad1_r;
  logic        swap1_r;

  assign u_c    = {ang_i, {(32 - ANGLE_BITS){1'b0}}};
  assign r_c    = u_c[29:0];
  assign swap_c = (r_c > Q30_QUARTER);
  assign rs_c   = swap_c ? 30'(Q30_ONE - {1'b0, r_c}) : r_c;
  assign th_prod = 61'(rs_c) * 61'(Q30_HALF_PI);

  always_ff @(posedge clk) begin
    if (en) begin
      th1_r   <= th_prod[59:30];
      quad1_r <= u_c[31:30];
      swap1_r <= swap_c;
    end
  end

  // Square of the octant angle
  logic [59:0] x2_prod;
  side_t       side2_r;

  assign x2_prod = 60'(th1_r) * 60'(th1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= '{th: th1_r, x2: x2_prod[59:30], quad: quad1_r, swap: swap1_r};
    end
  end

  // Horner steps: multiply by x^2, divide by the series constant, subtract from one
  side_t       side_m_r [HORNER_STEPS];
  side_t       side_d_r [HORNER_STEPS];
  side_t       side_s_r [HORNER_STEPS];
  logic [29:0] ps_r     [HORNER_STEPS];
  logic [29:0] pc_r     [HORNER_STEPS];
  logic [61:0] qs_r     [HORNER_STEPS];
  logic [61:0] qc_r     [HORNER_STEPS];
  logic [30:0] ts_r     [HORNER_STEPS];
  logic [30:0] tc_r     [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    side_t       side_in;
    logic [30:0] ts_in;
    logic [30:0] tc_in;
    logic [60:0] mps;
    logic [60:0] mpc;
    logic [61:0] rps;
    logic [61:0] rpc;
    logic [61:0] shs;
    logic [61:0] shc;

    if (j == 0) begin : g_first
      assign side_in = side2_r;
      assign ts_in   = Q30_ONE;
      assign tc_in   = Q30_ONE;
    end else begin : g_next
      assign side_in = side_s_r[j-1];
      assign ts_in   = ts_r[j-1];
      assign tc_in   = tc_r[j-1];
    end

    assign mps = 61'(side_in.x2) * 61'(ts_in);
    assign mpc = 61'(side_in.x2) * 61'(tc_in);
    assign rps = 62'(ps_r[j]) * 62'(SIN_RECIP[j]);
    assign rpc = 62'(pc_r[j]) * 62'(COS_RECIP[j]);
    assign shs = qs_r[j] >> SIN_SH[j];
    assign shc = qc_r[j] >> COS_SH[j];

    always_ff @(posedge clk) begin
      if (en) begin
        // x^2 * t
        ps_r[j]     <= mps[59:30];
        pc_r[j]     <= mpc[59:30];
        side_m_r[j] <= side_in;
        // reciprocal product
        qs_r[j]     <= rps;
        qc_r[j]     <= rpc;
        side_d_r[j] <= side_m_r[j];
        // t = 1 - quotient
        ts_r[j]     <= Q30_ONE - shs[30:0];
        tc_r[j]     <= Q30_ONE - shc[30:0];
        side_s_r[j] <= side_d_r[j];
      end
    end
  end

  // Final terms: sin = th * t, cos partial = x^2 * t
  side_t       side_l;
  logic [59:0] sin_prod;
  logic [59:0] cm_prod;
  logic [29:0] sin1_r;
  logic [29:0] cm1_r;
  logic [1:0]  quad2_r;
  logic        swap2_r;

  assign side_l   = side_s_r[HORNER_STEPS-1];
  assign sin_prod = 60'(side_l.th) * 60'(ts_r[HORNER_STEPS-1]);
  assign cm_prod  = 60'(side_l.x2) * 60'(tc_r[HORNER_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      sin1_r  <= sin_prod[59:30];
      cm1_r   <= cm_prod[59:30];
      quad2_r <= side_l.quad;
      swap2_r <= side_l.swap;
    end
  end

  // Finish cosine, undo the octant fold, map the quadrant
  logic [30:0] cos_c;
  logic [30:0] sv_c;
  logic [30:0] cv_c;
  logic [30:0] xm_c;
  logic [30:0] zm_c;
  logic        xn_c;
  logic        zn_c;
  logic [30:0] xm_r;
  logic [30:0] zm_r;
  logic        xn_r;
  logic        zn_r;

  assign cos_c = Q30_ONE - {2'b00, cm1_r[29:1]};
  assign sv_c  = swap2_r ? cos_c : {1'b0, sin1_r};
  assign cv_c  = swap2_r ? {1'b0, sin1_r} : cos_c;

  always_comb begin
    case (quad_t'(quad2_r))
      QUAD_I: begin
        xm_c = cv_c; xn_c = 1'b0; zm_c = sv_c; zn_c = 1'b0;
      end
      QUAD_II: begin
        xm_c = sv_c; xn_c = 1'b1; zm_c = cv_c; zn_c = 1'b0;
      end
      QUAD_III: begin
        xm_c = cv_c; xn_c = 1'b1; zm_c = sv_c; zn_c = 1'b1;
      end
      QUAD_IV: begin
        xm_c = sv_c; xn_c = 1'b0; zm_c = cv_c; zn_c = 1'b1;
      end
      default: begin
        xm_c = cv_c; xn_c = 1'b0; zm_c = sv_c; zn_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r <= xm_c;
      zm_r <= zm_c;
      xn_r <= xn_c;
      zn_r <= zn_c;
    end
  end

  // Scale by radius with round to nearest
  logic [47:0]        xp_c;
  logic [47:0]        zp_c;
  logic [COORD_W-1:0] xs_r;
  logic [COORD_W-1:0] zs_r;
  logic               xn2_r;
  logic               zn2_r;

  assign xp_c = 48'(radius_i) * 48'(xm_r) + Q30_RND;
  assign zp_c = 48'(radius_i) * 48'(zm_r) + Q30_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r  <= xp_c[46:30];
      zs_r  <= zp_c[46:30];
      xn2_r <= xn_r;
      zn2_r <= zn_r;
    end
  end

  // Apply sign
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= xn2_r ? $signed(-xs_r) : $signed(xs_r);
      z_r <= zn2_r ? $signed(-zs_r) : $signed(zs_r);
    end
  end

  assign x_o = x_r;
  assign z_o = z_r;

endmodule

>>> hw/rtl/helix_point_generator_unit.sv
// Top level of the helix point generator: registers, phase and height dividers, output skid.
//
//  Channel | Dir | Signals                              | Contents
//  in_     | in  | in_tvalid/in_tready/in_tdata[15:0]   | point_index
//  out_    | out | out_tvalid/out_tready/out_tdata[55:0]| x_coord, y_coord, z_coord
//          |     | out_tlast, out_tuser                 | is_last, in_range
//  cfg_    | in  | cfg_wr_en/cfg_addr[1:0]/cfg_wdata    | radius, total_length, count, turns
//
// One point per cycle while the skid register is empty. The depth is set by the
// bit-per-stage phase divider, PH_W = index bits + ANGLE_BITS + 9,
// and the 18-stage sine/cosine unit.
// Reset (rst_n, synchronous) loads the register defaults and empties the pipeline.
// A stalled output parks one result in a skid register; the pipeline holds while
// the skid register is full, so nothing is dropped or repeated.
`timescale 1ns / 1ps

module helix_point_generator_unit #(
  parameter int INDEX_BITS = hpg_pkg::INDEX_BITS_DEF,
  parameter int ANGLE_BITS = hpg_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hpg_pkg::IDX_IN_W-1:0]    in_tdata,    // [15:0] point_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hpg_pkg::TDATA_W-1:0]     out_tdata,   // [16:0] x, [32:17] y, [49:33] z
  output logic                            out_tlast,   // is_last
  output logic                            out_tuser,   // in_range
  input  logic                            cfg_wr_en,
  input  logic [hpg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hpg_pkg::CFG_W-1:0]       cfg_wdata
);

  import hpg_pkg::*;

  localparam int IW     = (INDEX_BITS < IDX_IN_W) ? INDEX_BITS : IDX_IN_W;
  localparam int PH_W   = IW + ANGLE_BITS + 9;
  localparam int YN_W   = IW + 17;
  localparam int Y_DLY  = PH_W - YN_W + SC_LAT;
  localparam int FL_DLY = PH_W + SC_LAT;

  // Configuration registers
  logic [CFG_W-1:0] radius_r;
  logic [CFG_W-1:0] length_r;
  logic [CFG_W-1:0] count_r;
  logic [CFG_W-1:0] turns_r;
  logic [CFG_W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      length_r <= RST_LENGTH;
      count_r  <= RST_COUNT;
      turns_r  <= RST_TURNS;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_LENGTH: length_r <= cfg_wdata;
        REG_COUNT:  count_r  <= cfg_wdata;
        REG_TURNS:  turns_r  <= cfg_wdata;
        default:    radius_r <= radius_r;
      endcase
    end
  end

  // Divisor count-1, at least one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= RST_COUNT - 16'd1;
    end else begin
      d_r <= (count_r > 16'd1) ? (count_r - 16'd1) : 16'd1;
    end
  end

  // Pipeline advance: held only while the skid register is occupied
  logic adv;
  logic skid_vld_r;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  // Input register
  logic          v1_r;
  logic [IW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= in_tdata[IW-1:0];
    end
  end

  // Products, rounding offsets and range flags
  logic [IW+CFG_W-1:0] ph_prod;
  logic [IW+CFG_W-1:0] y_prod;
  logic [CFG_W-1:0]    idx16;
  logic [PH_W-1:0]     n_ph_nxt;
  logic [YN_W-1:0]     n_y_nxt;
  pt_flags_t           fl_nxt;
  logic                v2_r;
  logic [PH_W-1:0]     n_ph_r;
  logic [YN_W-1:0]     n_y_r;
  pt_flags_t           fl_r;

  assign ph_prod  = (IW + CFG_W)'(idx_r) * (IW + CFG_W)'(turns_r);
  assign y_prod   = (IW + CFG_W)'(idx_r) * (IW + CFG_W)'(length_r);
  assign idx16    = CFG_W'(idx_r);
  assign n_ph_nxt = (PH_W'(ph_prod) << (ANGLE_BITS - 8)) + PH_W'(d_r >> 1);
  assign n_y_nxt  = YN_W'(y_prod) + YN_W'(d_r >> 1);
  assign fl_nxt.in_range = (idx16 < count_r);
  assign fl_nxt.is_last  = (idx16 == (count_r - 16'd1)) && (idx16 < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_ph_r <= n_ph_nxt;
      n_y_r  <= n_y_nxt;
      fl_r   <= fl_nxt;
    end
  end

  // Phase in turns: low ANGLE_BITS of the rounded quotient
  logic [ANGLE_BITS-1:0] ang;

  hpg_div_pipe #(
    .NUM_W (PH_W),
    .DIV_W (CFG_W),
    .QUO_W (ANGLE_BITS)
  ) u_phase_div (
    .clk   (clk),
    .en    (adv),
    .num_i (n_ph_r),
    .div_i (d_r),
    .quo_o (ang)
  );

  // Height
  logic [Y_W-1:0] y_quo;
  logic [Y_W-1:0] y_fin;

  hpg_div_pipe #(
    .NUM_W (YN_W),
    .DIV_W (CFG_W),
    .QUO_W (Y_W)
  ) u_height_div (
    .clk   (clk),
    .en    (adv),
    .num_i (n_y_r),
    .div_i (d_r),
    .quo_o (y_quo)
  );

  hpg_delay #(
    .WIDTH (Y_W),
    .LEN   (Y_DLY)
  ) u_height_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (y_quo),
    .q_o   (y_fin)
  );

  // Coordinates on the circle
  logic signed [COORD_W-1:0] x_fin;
  logic signed [COORD_W-1:0] z_fin;

  hpg_sincos #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sincos (
    .clk      (clk),
    .en       (adv),
    .radius_i (radius_r),
    .ang_i    (ang),
    .x_o      (x_fin),
    .z_o      (z_fin)
  );

  // Valid and flags beside the arithmetic
  logic      p_vld;
  pt_flags_t p_fl;

  hpg_delay #(
    .WIDTH (1),
    .LEN   (FL_DLY)
  ) u_valid_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (v2_r),
    .q_o   (p_vld)
  );

  hpg_delay #(
    .WIDTH ($bits(pt_flags_t)),
    .LEN   (FL_DLY)
  ) u_flags_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_i   (fl_r),
    .q_o   (p_fl)
  );

  // Zero the result for an index out of range
  pt_result_t p_res;

  always_comb begin
    p_res = '0;
    if (p_fl.in_range) begin
      p_res.x_coord  = x_fin;
      p_res.y_coord  = y_fin;
      p_res.z_coord  = z_fin;
      p_res.is_last  = p_fl.is_last;
      p_res.in_range = 1'b1;
    end
  end

  // Output register and skid register
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       skid_vld_nxt;
  logic       out_load;
  logic       skid_load;
  pt_result_t out_r;
  pt_result_t out_nxt;
  pt_result_t skid_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    out_nxt      = skid_r;
    if (out_tready || !out_vld_r) begin
      out_load = 1'b1;
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_nxt     = p_res;
        out_vld_nxt = p_vld;
      end
    end else if (p_vld && adv) begin
      skid_load    = 1'b1;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (skid_load) begin
      skid_r <= p_res;
    end
  end

  // Output packing
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(TDATA_W - 2 * COORD_W - Y_W){1'b0}},
                       out_r.z_coord, out_r.y_coord, out_r.x_coord};
  assign out_tlast  = out_r.is_last;
  assign out_tuser  = out_r.in_range;

endmodule
